FILE: hdl/fca_pkg.sv
// Shared constants, codes and types of the allocation-table chain manager.
// No dependencies.
package fca_pkg;

    localparam int FAT_ENTRIES = 256;
    localparam int BLOCK_BYTES = 512;
    localparam int OFF_W       = 9;
    localparam int NEED_W      = 10;
    localparam int ADDR_W      = 16;

    localparam logic [15:0] END_MARK  = 16'hFFFF;
    localparam logic [15:0] FREE_MARK = 16'h0000;

    localparam logic [2:0] MODE_WRITE  = 3'd0;
    localparam logic [2:0] MODE_READ   = 3'd1;
    localparam logic [2:0] MODE_EXTEND = 3'd2;
    localparam logic [2:0] MODE_CLEAR  = 3'd3;
    localparam logic [2:0] MODE_OVWR   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_CHAIN   = 2'd2;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       wdata;
    } mem_req_t;

endpackage

FILE: hdl/fca_if.sv
// Request and response channel interfaces (valid/ready with payload).
// No dependencies.
interface fca_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [7:0]  block_index;
    logic [15:0] entry_value;
    logic [17:0] current_size;
    logic [17:0] append_length;

    modport source (output valid, mode, block_index, entry_value, current_size,
                    append_length, input ready);
    modport sink (input valid, mode, block_index, entry_value, current_size,
                  append_length, output ready);
endinterface

interface fca_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] read_data;
    logic [7:0]  first_block;
    logic [8:0]  first_offset;
    logic [7:0]  last_block;
    logic [7:0]  blocks_added;

    modport source (output valid, status, read_data, first_block, first_offset,
                    last_block, blocks_added, input ready);
    modport sink (input valid, status, read_data, first_block, first_offset,
                  last_block, blocks_added, output ready);
endinterface

FILE: hdl/fca_mem.sv
// Allocation table storage: one write port, one registered read port.
// Depends on fca_pkg.
module fca_mem #(
    parameter int FAT_ENTRIES = fca_pkg::FAT_ENTRIES
) (
    input  logic               clk,
    input  fca_pkg::mem_req_t  mem_req,
    output logic [15:0]        rdata
);

    localparam int IW = $clog2(FAT_ENTRIES);

    logic [15:0] mem_array [FAT_ENTRIES];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem_array[mem_req.addr[IW-1:0]] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rdata_reg <= mem_array[mem_req.addr[IW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/fca_ctrl.sv
// Request sequencer: entry access, chain walk, clear, free-block scan and linking.
// Depends on fca_pkg, fca_if; drives the table memory through fca_pkg::mem_req_t.
module fca_ctrl #(
    parameter int FAT_ENTRIES = fca_pkg::FAT_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    fca_req_if.sink           req,
    fca_rsp_if.source         rsp,
    output fca_pkg::mem_req_t mem_req,
    input  logic [15:0]       mem_rdata
);

    localparam int IW = $clog2(FAT_ENTRIES);
    localparam int CW = $clog2(FAT_ENTRIES + 1);

    localparam logic [4:0] S_INIT     = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_WR_RD    = 5'd2;
    localparam logic [4:0] S_WR_WR    = 5'd3;
    localparam logic [4:0] S_RD       = 5'd4;
    localparam logic [4:0] S_RD_GET   = 5'd5;
    localparam logic [4:0] S_WALK     = 5'd6;
    localparam logic [4:0] S_WALK_CHK = 5'd7;
    localparam logic [4:0] S_CLR_RD   = 5'd8;
    localparam logic [4:0] S_CLR_WR   = 5'd9;
    localparam logic [4:0] S_CLR_END  = 5'd10;
    localparam logic [4:0] S_EXT_INIT = 5'd11;
    localparam logic [4:0] S_LINK_CHK = 5'd12;
    localparam logic [4:0] S_SCAN     = 5'd13;
    localparam logic [4:0] S_LINK1    = 5'd14;
    localparam logic [4:0] S_LINK2    = 5'd15;
    localparam logic [4:0] S_DONE     = 5'd16;

    logic [4:0]        state_reg;
    logic [IW-1:0]     init_cnt_reg;
    logic [2:0]        mode_reg;
    logic [IW-1:0]     idx_reg;
    logic [15:0]       val_reg;
    logic [17:0]       csize_reg;
    logic [17:0]       len_reg;
    logic [IW-1:0]     cur_reg;
    logic [IW-1:0]     steps_reg;
    logic [IW-1:0]     last_reg;
    logic [IW-1:0]     nb_reg;
    logic [IW-1:0]     scan_addr_reg;
    logic [IW-1:0]     scan_prev_reg;
    logic              scan_vld_reg;
    logic [fca_pkg::NEED_W-1:0] need_reg;
    logic [CW-1:0]     added_reg;
    logic [CW-1:0]     free_reg;
    logic              have_first_reg;

    logic [1:0]        res_status_reg;
    logic [15:0]       res_rdata_reg;
    logic [7:0]        res_fblock_reg;
    logic [8:0]        res_foff_reg;

    logic              rsp_valid_reg;
    logic [1:0]        rsp_status_reg;
    logic [15:0]       rsp_rdata_reg;
    logic [7:0]        rsp_fblock_reg;
    logic [8:0]        rsp_foff_reg;
    logic [7:0]        rsp_last_reg;
    logic [7:0]        rsp_added_reg;

    logic [fca_pkg::OFF_W-1:0]  ext_offset;
    logic [fca_pkg::NEED_W-1:0] ext_room;
    logic [18:0]                ext_span;
    logic [fca_pkg::NEED_W-1:0] ext_need;
    logic                       scan_hit;
    logic                       req_bad_idx;

    assign ext_offset = csize_reg[fca_pkg::OFF_W-1:0];
    assign ext_room   = (csize_reg != 18'd0 && ext_offset == '0) ? '0
                        : fca_pkg::NEED_W'(fca_pkg::BLOCK_BYTES)
                          - fca_pkg::NEED_W'(ext_offset);
    assign ext_span   = 19'(len_reg) - 19'(ext_room) + 19'(fca_pkg::BLOCK_BYTES - 1);
    assign ext_need   = (19'(len_reg) > 19'(ext_room))
                        ? fca_pkg::NEED_W'(ext_span >> fca_pkg::OFF_W) : '0;
    assign scan_hit   = scan_vld_reg && (mem_rdata == fca_pkg::FREE_MARK);
    assign req_bad_idx = int'(req.block_index) >= FAT_ENTRIES;

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.read_data    = rsp_rdata_reg;
    assign rsp.first_block  = rsp_fblock_reg;
    assign rsp.first_offset = rsp_foff_reg;
    assign rsp.last_block   = rsp_last_reg;
    assign rsp.blocks_added = rsp_added_reg;

    always_comb
    begin
        mem_req = '{we: 1'b0, re: 1'b0, addr: '0, wdata: fca_pkg::FREE_MARK};
        case (state_reg)
            S_INIT:
            begin
                mem_req.we   = 1'b1;
                mem_req.addr = fca_pkg::ADDR_W'(init_cnt_reg);
            end
            S_WR_RD, S_RD:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = fca_pkg::ADDR_W'(idx_reg);
            end
            S_WR_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = fca_pkg::ADDR_W'(idx_reg);
                mem_req.wdata = val_reg;
            end
            S_WALK, S_CLR_RD:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = fca_pkg::ADDR_W'(cur_reg);
            end
            S_CLR_WR:
            begin
                mem_req.we   = 1'b1;
                mem_req.addr = fca_pkg::ADDR_W'(cur_reg);
            end
            S_CLR_END:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = fca_pkg::ADDR_W'(idx_reg);
                mem_req.wdata = fca_pkg::END_MARK;
            end
            S_SCAN:
            begin
                mem_req.re   = !scan_hit;
                mem_req.addr = fca_pkg::ADDR_W'(scan_addr_reg);
            end
            S_LINK1:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = fca_pkg::ADDR_W'(last_reg);
                mem_req.wdata = 16'(nb_reg);
            end
            S_LINK2:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = fca_pkg::ADDR_W'(nb_reg);
                mem_req.wdata = fca_pkg::END_MARK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_cnt_reg  <= '0;
            free_reg      <= CW'(FAT_ENTRIES);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && state_reg != S_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT:
                begin
                    init_cnt_reg <= init_cnt_reg + 1'b1;
                    if (init_cnt_reg == IW'(FAT_ENTRIES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        mode_reg       <= req.mode;
                        idx_reg        <= IW'(req.block_index);
                        cur_reg        <= IW'(req.block_index);
                        val_reg        <= req.entry_value;
                        csize_reg      <= req.current_size;
                        len_reg        <= req.append_length;
                        steps_reg      <= '0;
                        added_reg      <= '0;
                        have_first_reg <= 1'b0;
                        last_reg       <= '0;
                        res_status_reg <= fca_pkg::ST_OK;
                        res_rdata_reg  <= '0;
                        res_fblock_reg <= '0;
                        res_foff_reg   <= '0;
                        case (req.mode)
                            fca_pkg::MODE_WRITE, fca_pkg::MODE_READ:
                            begin
                                if (req_bad_idx)
                                begin
                                    res_status_reg <= fca_pkg::ST_CHAIN;
                                    state_reg      <= S_DONE;
                                end
                                else if (req.mode == fca_pkg::MODE_WRITE)
                                begin
                                    state_reg <= S_WR_RD;
                                end
                                else
                                begin
                                    state_reg <= S_RD;
                                end
                            end
                            fca_pkg::MODE_EXTEND, fca_pkg::MODE_CLEAR,
                            fca_pkg::MODE_OVWR:
                            begin
                                if (req_bad_idx)
                                begin
                                    res_status_reg <= fca_pkg::ST_CHAIN;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_WALK;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_WR_RD:
                begin
                    state_reg <= S_WR_WR;
                end
                S_WR_WR:
                begin
                    if (mem_rdata == fca_pkg::FREE_MARK && val_reg != fca_pkg::FREE_MARK)
                    begin
                        free_reg <= free_reg - 1'b1;
                    end
                    else if (mem_rdata != fca_pkg::FREE_MARK &&
                             val_reg == fca_pkg::FREE_MARK)
                    begin
                        free_reg <= free_reg + 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_RD:
                begin
                    state_reg <= S_RD_GET;
                end
                S_RD_GET:
                begin
                    res_rdata_reg <= mem_rdata;
                    state_reg     <= S_DONE;
                end
                S_WALK:
                begin
                    state_reg <= S_WALK_CHK;
                end
                S_WALK_CHK:
                begin
                    if (mem_rdata == fca_pkg::END_MARK)
                    begin
                        if (mode_reg == fca_pkg::MODE_EXTEND)
                        begin
                            last_reg  <= cur_reg;
                            state_reg <= S_EXT_INIT;
                        end
                        else
                        begin
                            cur_reg   <= idx_reg;
                            state_reg <= S_CLR_RD;
                        end
                    end
                    else if (int'(mem_rdata) >= FAT_ENTRIES ||
                             steps_reg == IW'(FAT_ENTRIES - 1))
                    begin
                        res_status_reg <= fca_pkg::ST_CHAIN;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        cur_reg   <= IW'(mem_rdata);
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_WALK;
                    end
                end
                S_CLR_RD:
                begin
                    state_reg <= S_CLR_WR;
                end
                S_CLR_WR:
                begin
                    if (mem_rdata != fca_pkg::FREE_MARK)
                    begin
                        free_reg <= free_reg + 1'b1;
                    end
                    if (mem_rdata == fca_pkg::END_MARK || int'(mem_rdata) >= FAT_ENTRIES)
                    begin
                        state_reg <= S_CLR_END;
                    end
                    else
                    begin
                        cur_reg   <= IW'(mem_rdata);
                        state_reg <= S_CLR_RD;
                    end
                end
                S_CLR_END:
                begin
                    // start block was freed by the sweep, so marking it always takes one
                    free_reg <= free_reg - 1'b1;
                    last_reg <= idx_reg;
                    if (mode_reg == fca_pkg::MODE_OVWR)
                    begin
                        csize_reg <= '0;
                        state_reg <= S_EXT_INIT;
                    end
                    else
                    begin
                        state_reg <= S_LINK_CHK;
                    end
                end
                S_EXT_INIT:
                begin
                    need_reg      <= ext_need;
                    scan_addr_reg <= '0;
                    if (len_reg != 18'd0 && ext_room != '0)
                    begin
                        res_fblock_reg <= 8'(last_reg);
                        res_foff_reg   <= ext_offset;
                        have_first_reg <= 1'b1;
                    end
                    state_reg <= S_LINK_CHK;
                end
                S_LINK_CHK:
                begin
                    scan_vld_reg <= 1'b0;
                    if (mode_reg == fca_pkg::MODE_CLEAR ||
                        int'(added_reg) == int'(need_reg))
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (free_reg == '0)
                    begin
                        res_status_reg <= fca_pkg::ST_NOSPACE;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (scan_hit)
                    begin
                        nb_reg    <= scan_prev_reg;
                        state_reg <= S_LINK1;
                    end
                    else
                    begin
                        scan_prev_reg <= scan_addr_reg;
                        scan_vld_reg  <= 1'b1;
                        scan_addr_reg <= scan_addr_reg + 1'b1;
                    end
                end
                S_LINK1:
                begin
                    // linking to block 0 writes the free mark into the old end
                    if (nb_reg == '0)
                    begin
                        free_reg <= free_reg + 1'b1;
                    end
                    state_reg <= S_LINK2;
                end
                S_LINK2:
                begin
                    free_reg  <= free_reg - 1'b1;
                    last_reg  <= nb_reg;
                    added_reg <= added_reg + 1'b1;
                    if (!have_first_reg)
                    begin
                        res_fblock_reg <= 8'(nb_reg);
                        res_foff_reg   <= '0;
                        have_first_reg <= 1'b1;
                    end
                    if (nb_reg == '0 || nb_reg == IW'(FAT_ENTRIES - 1))
                    begin
                        scan_addr_reg <= '0;
                    end
                    else
                    begin
                        scan_addr_reg <= nb_reg + 1'b1;
                    end
                    state_reg <= S_LINK_CHK;
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= res_status_reg;
                        rsp_rdata_reg  <= res_rdata_reg;
                        rsp_fblock_reg <= res_fblock_reg;
                        rsp_foff_reg   <= res_foff_reg;
                        rsp_last_reg   <= 8'(last_reg);
                        rsp_added_reg  <= 8'(added_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(free_reg) <= FAT_ENTRIES)
        else $error("free count above table size");

    a_link_need: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK2) |-> (int'(added_reg) < int'(need_reg)))
        else $error("link beyond blocks needed");

    a_done_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!rsp_valid_reg || rsp.ready)) |=> rsp_valid_reg)
        else $error("finished transaction not presented");

    a_scan_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (free_reg != '0))
        else $error("scan started with no free block");

endmodule

FILE: hdl/fat_chain_allocator_top.sv
// Steps: write reads the entry, then writes it; read reads it, then captures it; extend, clear
// and overwrite walk the chain hop by hop; clear and overwrite free it block by block; per new
// block a scan for a free entry, then a link and a recheck; results leave through a register.
// One transaction at a time; the read-then-write table accesses set the pace.
// After reset a clearing pass zeroes every table entry; no request is taken until it ends.
// Top level: ties the request sequencer to the table memory. Depends on fca_pkg, fca_if, fca_ctrl, fca_mem.
module fat_chain_allocator_top #(
    parameter int FAT_ENTRIES = fca_pkg::FAT_ENTRIES
) (
    input  logic      clk,
    input  logic      rst_n,
    fca_req_if.sink   req,
    fca_rsp_if.source rsp
);

    fca_pkg::mem_req_t mem_req;
    logic [15:0]       mem_rdata;

    fca_ctrl #(.FAT_ENTRIES(FAT_ENTRIES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    fca_mem #(.FAT_ENTRIES(FAT_ENTRIES)) u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (mem_rdata)
    );

endmodule
